// ----- sv/nfta_pkg.sv -----
// Shared constants, request codes and beat types for the next-fit slot allocator.
`default_nettype none

package nfta_pkg;

  localparam int NUM_SLOTS  = 256;
  localparam int KIND_BITS  = 4;
  localparam int NUM_KINDS  = 1 << KIND_BITS;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W      = $clog2(NUM_SLOTS + 1);

  // Search granularity: one group of slots is examined per cycle.
  localparam int GROUP_W    = 16;
  localparam int NUM_GROUPS = NUM_SLOTS / GROUP_W;
  localparam int OFF_W      = $clog2(GROUP_W);
  localparam int GRP_W      = $clog2(NUM_GROUPS);
  localparam int STEP_W     = $clog2(NUM_GROUPS + 1);

  localparam logic [1:0] REQ_ALLOC    = 2'd0;
  localparam logic [1:0] REQ_FREE     = 2'd1;
  localparam logic [1:0] REQ_FREE_ALL = 2'd2;
  localparam logic [1:0] REQ_COUNT    = 2'd3;

  typedef logic [NUM_SLOTS-1:0] bitmap_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] entity_kind;
    logic [7:0] slot_index;
  } in_beat_t;

  typedef struct packed {
    logic       granted;
    logic [7:0] granted_slot;
    logic [8:0] kind_count;
  } out_beat_t;

  typedef struct packed {
    logic              go;
    logic [SLOT_W-1:0] start_pos;
  } scan_req_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] slot;
  } scan_rsp_t;

endpackage

`default_nettype wire

// ----- sv/next_fit_typed_slot_allocator.sv -----
// Top level: request sequencer, active bitmap, per-kind counters and kind store.
//
// One request is taken when start is high and busy is low; each request
// returns exactly one result beat, shown for one cycle with out_valid. The
// receiver cannot stall, so results are never held. Count and free-all results
// appear in the cycle after acceptance; free-one passes through ST_FREE while
// the kind store, which has registered read data, returns the kind. Allocate
// passes through ST_SCAN: the search examines one 16-slot group per cycle,
// starting at the group of the last grant, and revisits that group once after
// wrapping. busy drops in the cycle the result appears, so a new request can
// be accepted alongside it. Counts come from per-kind counters kept up to
// date on every grant and free; no clearing pass is needed after reset.
`default_nettype none

module next_fit_typed_slot_allocator import nfta_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_beat_t in_data,
  output logic          out_valid,
  output out_beat_t     out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FREE = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [KIND_BITS-1:0] kind_r, kind_nxt;
  logic                 was_act_r, was_act_nxt;
  logic [SLOT_W-1:0]    search_start_r, search_start_nxt;
  bitmap_t              active_r, active_nxt;
  logic [CNT_W-1:0]     cnt_r [NUM_KINDS];
  logic [CNT_W-1:0]     cnt_nxt [NUM_KINDS];
  logic                 out_valid_r, out_valid_nxt;
  out_beat_t            out_data_r, out_data_nxt;

  logic                 accept;
  logic [KIND_BITS-1:0] in_kind;
  logic [SLOT_W-1:0]    in_slot;
  logic                 in_range;
  scan_req_t            scan_req;
  scan_rsp_t            scan_rsp;
  logic                 mem_we;
  logic                 mem_re;
  logic [KIND_BITS-1:0] mem_rdata;

  assign accept   = start & ~busy;
  assign busy     = (state_r != ST_IDLE);
  assign in_kind  = in_data.entity_kind[KIND_BITS-1:0];
  assign in_slot  = SLOT_W'(in_data.slot_index);
  assign in_range = ({24'd0, in_data.slot_index} < 32'(NUM_SLOTS));

  assign scan_req.go        = accept & (in_data.req_type == REQ_ALLOC);
  assign scan_req.start_pos = search_start_r;

  assign mem_re = accept & (in_data.req_type == REQ_FREE);
  assign mem_we = (state_r == ST_SCAN) & scan_rsp.done & scan_rsp.found;

  nfta_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (scan_req),
    .active (active_r),
    .rsp    (scan_rsp)
  );

  nfta_ram #(
    .WIDTH (KIND_BITS),
    .DEPTH (NUM_SLOTS)
  ) u_kind_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (scan_rsp.slot),
    .wdata (kind_r),
    .re    (mem_re),
    .raddr (in_slot),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt        = state_r;
    kind_nxt         = kind_r;
    was_act_nxt      = was_act_r;
    search_start_nxt = search_start_r;
    active_nxt       = active_r;
    for (int k = 0; k < NUM_KINDS; k++) begin
      cnt_nxt[k] = cnt_r[k];
    end
    out_valid_nxt    = 1'b0;
    out_data_nxt     = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt = in_kind;
          case (in_data.req_type)
            REQ_ALLOC: begin
              state_nxt = ST_SCAN;
            end
            REQ_FREE: begin
              // Drop the active bit now; fix the counter once the kind is read.
              was_act_nxt = in_range & active_r[in_slot];
              if (in_range) begin
                active_nxt[in_slot] = 1'b0;
              end
              state_nxt = ST_FREE;
            end
            REQ_FREE_ALL: begin
              active_nxt = '0;
              for (int k = 0; k < NUM_KINDS; k++) begin
                cnt_nxt[k] = '0;
              end
              out_valid_nxt = 1'b1;
            end
            REQ_COUNT: begin
              out_valid_nxt           = 1'b1;
              out_data_nxt.kind_count = 9'(cnt_r[in_kind]);
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_rsp.done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (scan_rsp.found) begin
            active_nxt[scan_rsp.slot] = 1'b1;
            cnt_nxt[kind_r]           = cnt_r[kind_r] + CNT_W'(1);
            search_start_nxt          = scan_rsp.slot;
            out_data_nxt.granted      = 1'b1;
            out_data_nxt.granted_slot = 8'(scan_rsp.slot);
          end
        end
      end
      ST_FREE: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        if (was_act_r) begin
          cnt_nxt[mem_rdata] = cnt_r[mem_rdata] - CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      search_start_r <= '0;
      active_r       <= '0;
      for (int k = 0; k < NUM_KINDS; k++) begin
        cnt_r[k] <= '0;
      end
      out_valid_r    <= 1'b0;
      was_act_r      <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      search_start_r <= search_start_nxt;
      active_r       <= active_nxt;
      for (int k = 0; k < NUM_KINDS; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
      out_valid_r    <= out_valid_nxt;
      was_act_r      <= was_act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- sv/nfta_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module nfta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/nfta_scan.sv -----
// Circular first-free search over the active bitmap, one group of slots per cycle.
`default_nettype none

module nfta_scan import nfta_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire scan_req_t req,
  input  wire bitmap_t   active,
  output scan_rsp_t      rsp
);

  logic              run_r;
  logic [GRP_W-1:0]  grp_r;
  logic [OFF_W-1:0]  off_r;
  logic [STEP_W-1:0] step_r;

  logic [GROUP_W-1:0] word;
  logic [GROUP_W-1:0] cand;
  logic               first_step;
  logic               last_step;
  logic               any_free;
  logic [OFF_W-1:0]   hit_bit;

  assign word       = active[grp_r * GROUP_W +: GROUP_W];
  assign first_step = (step_r == STEP_W'(0));
  assign last_step  = (step_r == STEP_W'(NUM_GROUPS));

  // The start group is visited twice: first from the start offset upward,
  // last (after wrapping) below the start offset.
  always_comb begin
    for (int i = 0; i < GROUP_W; i++) begin
      if (first_step) begin
        cand[i] = ~word[i] & (OFF_W'(i) >= off_r);
      end else if (last_step) begin
        cand[i] = ~word[i] & (OFF_W'(i) < off_r);
      end else begin
        cand[i] = ~word[i];
      end
    end
  end

  always_comb begin
    hit_bit = '0;
    for (int i = GROUP_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_bit = OFF_W'(i);
      end
    end
  end

  assign any_free  = |cand;
  assign rsp.done  = run_r & (any_free | last_step);
  assign rsp.found = any_free;
  assign rsp.slot  = {grp_r, hit_bit};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      grp_r  <= '0;
      off_r  <= '0;
      step_r <= '0;
    end else if (req.go) begin
      run_r  <= 1'b1;
      grp_r  <= req.start_pos[SLOT_W-1:OFF_W];
      off_r  <= req.start_pos[OFF_W-1:0];
      step_r <= '0;
    end else if (run_r) begin
      if (rsp.done) begin
        run_r <= 1'b0;
      end else begin
        grp_r  <= (grp_r == GRP_W'(NUM_GROUPS - 1)) ? '0 : grp_r + GRP_W'(1);
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the next-fit typed slot allocator.
`timescale 1ns / 1ps

module tb_top import nfta_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int MAX_GAP = 20;

  typedef struct {
    in_beat_t  beat;
    bit        fixed;
    out_beat_t res;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_data;
  logic      out_valid;
  out_beat_t out_data;

  // Shadow of the pool, updated at every accepted request.
  bitmap_t           pool_active;
  logic [KIND_BITS-1:0] pool_kind [NUM_SLOTS];
  logic [SLOT_W-1:0] next_fit_ptr;

  out_beat_t   pending_results[$];
  out_beat_t   expected_beat;
  stim_row_t   directed_rows[$];
  int          fail_count;
  int          sender_idle_pct;
  int          req_tally[4];
  int          grants_seen;
  int          full_rejects;
  int          peak_count;
  int unsigned cycle_count;

  next_fit_typed_slot_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic out_beat_t predict_slot_op(input in_beat_t b);
    out_beat_t r;
    int pos;
    int n;
    r = '0;
    case (b.req_type)
      REQ_ALLOC: begin
        pos = next_fit_ptr;
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (!pool_active[pos]) begin
            pool_active[pos] = 1'b1;
            pool_kind[pos] = b.entity_kind[KIND_BITS-1:0];
            next_fit_ptr = SLOT_W'(pos);
            r.granted = 1'b1;
            r.granted_slot = 8'(pos);
            break;
          end
          pos = (pos + 1) % NUM_SLOTS;
        end
      end
      REQ_FREE: begin
        if (int'(b.slot_index) < NUM_SLOTS) pool_active[b.slot_index] = 1'b0;
      end
      REQ_FREE_ALL: begin
        pool_active = '0;
      end
      default: begin
        n = 0;
        for (int k = 0; k < NUM_SLOTS; k++)
          if (pool_active[k] && pool_kind[k] == b.entity_kind[KIND_BITS-1:0] && n < 511)
            n++;
        r.kind_count = 9'(n);
      end
    endcase
    return r;
  endfunction

  // First active slot at or after a random point; a random slot if the pool is empty.
  function automatic logic [7:0] pick_active_slot();
    int s0;
    s0 = $urandom_range(NUM_SLOTS - 1);
    for (int k = 0; k < NUM_SLOTS; k++)
      if (pool_active[(s0 + k) % NUM_SLOTS]) return 8'((s0 + k) % NUM_SLOTS);
    return 8'(s0);
  endfunction

  function automatic stim_row_t row(input logic [1:0] req, input int kind, input int idx,
                                    input bit fixed, input int g, input int gs, input int cnt);
    stim_row_t s;
    s.beat.req_type = req;
    s.beat.entity_kind = 4'(kind);
    s.beat.slot_index = 8'(idx);
    s.fixed = fixed;
    s.res.granted = 1'(g);
    s.res.granted_slot = 8'(gs);
    s.res.kind_count = 9'(cnt);
    return s;
  endfunction

  function automatic in_beat_t random_req(input bit grow);
    in_beat_t b;
    int r;
    b.entity_kind = 4'($urandom);
    b.slot_index = 8'($urandom);
    r = $urandom_range(99);
    if (!grow && r < 1) begin
      b.req_type = REQ_FREE_ALL;
    end else if (r < (grow ? 62 : 22)) begin
      b.req_type = REQ_ALLOC;
    end else if (r < 80) begin
      b.req_type = REQ_FREE;
      if ($urandom_range(3) != 0) b.slot_index = pick_active_slot();
    end else begin
      b.req_type = REQ_COUNT;
      if ($urandom_range(1) != 0) b.entity_kind = pool_kind[pick_active_slot()];
    end
    return b;
  endfunction

  task automatic issue_req(input in_beat_t b, input bit fixed, input out_beat_t fixed_res);
    out_beat_t predicted;
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_slot_op(b);
    pending_results.push_back(fixed ? fixed_res : predicted);
    req_tally[b.req_type]++;
    if (b.req_type == REQ_ALLOC) begin
      if (predicted.granted) grants_seen++;
      else full_rejects++;
    end
    if (int'(predicted.kind_count) > peak_count) peak_count = int'(predicted.kind_count);
  endtask

  task automatic issue_random(input in_beat_t b);
    issue_req(b, 1'b0, '0);
  endtask

  // Result checker: compare each beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: granted=%0d granted_slot=%0d kind_count=%0d",
               out_data.granted, out_data.granted_slot, out_data.kind_count);
        fail_count++;
      end else begin
        expected_beat = pending_results.pop_front();
        if (out_data.granted !== expected_beat.granted) begin
          $error("granted: expected %0d, got %0d", expected_beat.granted, out_data.granted);
          fail_count++;
        end
        if (out_data.granted_slot !== expected_beat.granted_slot) begin
          $error("granted_slot: expected %0d, got %0d",
                 expected_beat.granted_slot, out_data.granted_slot);
          fail_count++;
        end
        if (out_data.kind_count !== expected_beat.kind_count) begin
          $error("kind_count: expected %0d, got %0d",
                 expected_beat.kind_count, out_data.kind_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    in_beat_t b;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    fail_count = 0;
    sender_idle_pct = 0;
    grants_seen = 0;
    full_rejects = 0;
    peak_count = 0;
    cycle_count = 0;
    foreach (req_tally[i]) req_tally[i] = 0;
    pool_active = '0;
    foreach (pool_kind[i]) pool_kind[i] = '0;
    next_fit_ptr = '0;

    directed_rows = '{
      row(REQ_COUNT,     0,   0, 1, 0, 0, 0),
      row(REQ_COUNT,    15, 255, 1, 0, 0, 0),
      row(REQ_FREE,      0,   0, 1, 0, 0, 0),
      row(REQ_FREE_ALL,  0,   0, 1, 0, 0, 0),
      row(REQ_ALLOC,    15,   0, 1, 1, 0, 0),
      row(REQ_ALLOC,     0,   0, 1, 1, 1, 0),
      row(REQ_COUNT,    15,   0, 1, 0, 0, 1),
      row(REQ_COUNT,     0,   0, 1, 0, 0, 1),
      row(REQ_FREE,     15, 255, 1, 0, 0, 0),
      row(REQ_FREE,      0,   0, 1, 0, 0, 0),
      row(REQ_ALLOC,     7, 255, 1, 1, 2, 0),
      row(REQ_ALLOC,     7,   0, 1, 1, 3, 0),
      row(REQ_COUNT,     7,   0, 1, 0, 0, 2),
      row(REQ_COUNT,    15,   0, 1, 0, 0, 0),
      row(REQ_FREE_ALL, 15, 255, 1, 0, 0, 0),
      row(REQ_COUNT,     7,   0, 1, 0, 0, 0),
      // pointer survives free-all, so the search resumes at slot 3
      row(REQ_ALLOC,     9,   0, 1, 1, 3, 0),
      row(REQ_COUNT,     9,   0, 1, 0, 0, 1),
      row(REQ_FREE,     15,   3, 1, 0, 0, 0),
      row(REQ_ALLOC,    10,   0, 1, 1, 3, 0),
      row(REQ_FREE,      0,   3, 1, 0, 0, 0)
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      issue_req(directed_rows[i].beat, directed_rows[i].fixed, directed_rows[i].res);

    // Fill the whole pool with one kind, wrapping past the top slot.
    for (int i = 0; i < NUM_SLOTS; i++) begin
      b.req_type = REQ_ALLOC;
      b.entity_kind = 4'd12;
      b.slot_index = 8'($urandom);
      issue_random(b);
    end
    issue_req('{REQ_ALLOC, 4'd3, 8'd0}, 1'b1, '{1'b0, 8'd0, 9'd0});
    issue_req('{REQ_COUNT, 4'd12, 8'd0}, 1'b1, '{1'b0, 8'd0, 9'd256});
    issue_random('{REQ_COUNT, 4'd11, 8'd0});
    // Lone holes in a full pool: two far from the pointer force long searches, one sits at the pointer.
    issue_random('{REQ_FREE, 4'd0, 8'd100});
    issue_random('{REQ_ALLOC, 4'd5, 8'd0});
    issue_random('{REQ_FREE, 4'd0, 8'd1});
    issue_random('{REQ_ALLOC, 4'd6, 8'd0});
    issue_random('{REQ_FREE, 4'd0, 8'd1});
    issue_random('{REQ_ALLOC, 4'd14, 8'd0});
    // Hole just below the pointer: found only after wrapping back to its group.
    issue_random('{REQ_FREE, 4'd0, 8'd0});
    issue_random('{REQ_ALLOC, 4'd8, 8'd0});
    issue_random('{REQ_COUNT, 4'd5, 8'd0});

    for (int phase = 0; phase < 3; phase++) begin
      bit grow;
      sender_idle_pct = (phase == 0) ? 0 : (phase == 1) ? 58 : 8;
      grow = 1'b0;
      for (int i = 0; i < 190; i++) begin
        if (i % 40 == 0) grow = 1'($urandom_range(1));
        issue_random(random_req(grow));
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (NUM_GROUPS + 4) @(posedge clk);

    $display("Covered %0d allocate, %0d free, %0d free-all, %0d count requests.",
             req_tally[REQ_ALLOC], req_tally[REQ_FREE], req_tally[REQ_FREE_ALL],
             req_tally[REQ_COUNT]);
    $display("Grants %0d, full-pool rejects %0d, highest kind count %0d.",
             grants_seen, full_rejects, peak_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
